// File: rtl/gfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_pkg
// Shared constants and types of the gamepad frame receiver.
// ----------------------------------------------------------------------------
package gfr_pkg;

   localparam int TIMER_BITS    = 16;
   localparam int CFG_BITS      = 16;
   localparam int CMP_BITS      = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int BYTE_BITS     = 8;
   localparam int WORD_BITS     = 32;
   localparam int BUTTON_BITS   = 16;
   localparam int PAYLOAD_LEN   = 26;
   localparam int AXIS_BYTES    = 24;
   localparam int COUNT_BITS    = 5;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [BYTE_BITS-1:0] SYNC_FIRST  = 8'd67;
   localparam logic [BYTE_BITS-1:0] SYNC_SECOND = 8'd114;

   localparam logic [CFG_BITS-1:0] RX_TIMEOUT_RESET   = 16'd50;
   localparam logic [CFG_BITS-1:0] SAFE_TIMEOUT_RESET = 16'd250;

   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   localparam logic REG_RX_TIMEOUT   = 1'b0;
   localparam logic REG_SAFE_TIMEOUT = 1'b1;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [CMP_BITS-1:0]   cmp_type;
   typedef logic [BYTE_BITS-1:0]  byte_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] receive_timeout_ms;
      logic [CFG_BITS-1:0] safety_timeout_ms;
   } cfg_type;

endpackage
`default_nettype wire

// File: rtl/gfr_channels.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_channels
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface gfr_req_if;
   logic                            valid;
   logic                            ready;
   logic                            action;
   logic [gfr_pkg::BYTE_BITS-1:0]   data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface gfr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [gfr_pkg::WORD_BITS-1:0]     left_x;
   logic [gfr_pkg::WORD_BITS-1:0]     left_y;
   logic [gfr_pkg::WORD_BITS-1:0]     right_x;
   logic [gfr_pkg::WORD_BITS-1:0]     right_y;
   logic [gfr_pkg::WORD_BITS-1:0]     left_trigger;
   logic [gfr_pkg::WORD_BITS-1:0]     right_trigger;
   logic [gfr_pkg::BUTTON_BITS-1:0]   buttons;
   logic                              frame_done;
   logic                              halt_request;
   logic                              link_led;

   modport source (output valid, left_x, left_y, right_x, right_y, left_trigger,
                   right_trigger, buttons, frame_done, halt_request, link_led,
                   input ready);
   modport sink   (input valid, left_x, left_y, right_x, right_y, left_trigger,
                   right_trigger, buttons, frame_done, halt_request, link_led,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/gfr_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gfr_csr
// APB register file holding the receive and safety timeouts.
// ----------------------------------------------------------------------------
module gfr_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gfr_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [gfr_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output      logic [gfr_pkg::CSR_DATA_BITS-1:0]   prdata,
   output      logic                                pready,
   output      gfr_pkg::cfg_type                    cfg
);

   gfr_pkg::cfg_type cfg_ff;
   gfr_pkg::cfg_type cfg_in;
   logic             reg_index;
   logic             wr_fire;

   assign reg_index = paddr[2];
   assign wr_fire   = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_index)
            gfr_pkg::REG_RX_TIMEOUT: begin
               cfg_in.receive_timeout_ms = pwdata[gfr_pkg::CFG_BITS-1:0];
            end
            gfr_pkg::REG_SAFE_TIMEOUT: begin
               cfg_in.safety_timeout_ms = pwdata[gfr_pkg::CFG_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         gfr_pkg::REG_RX_TIMEOUT: begin
            prdata = gfr_pkg::CSR_DATA_BITS'(cfg_ff.receive_timeout_ms);
         end
         gfr_pkg::REG_SAFE_TIMEOUT: begin
            prdata = gfr_pkg::CSR_DATA_BITS'(cfg_ff.safety_timeout_ms);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.receive_timeout_ms <= gfr_pkg::RX_TIMEOUT_RESET;
         cfg_ff.safety_timeout_ms  <= gfr_pkg::SAFE_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/gamepad_frame_receiver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_frame_receiver_unit
// Sync hunt, payload capture, frame timing and safety halt for a gamepad link.
// ----------------------------------------------------------------------------
// Result: each accepted input beat is registered and shown as its result beat in the next cycle.
// Throughput: one input beat per cycle; the single result register refills
//   in the cycle it is drained, so input stalls only while a result is held.
// Reset: synchronous, active high; clears receive state, payload, counters,
//   LED and result valid, and loads the timeout registers with 50 and 250.
// ----------------------------------------------------------------------------
module gamepad_frame_receiver_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   gfr_req_if.sink                                  req_chan,
   gfr_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [gfr_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  wire logic [gfr_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output      logic [gfr_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output      logic                                csr_pready
);

   gfr_pkg::cfg_type cfg;

   gfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   logic                                rx_active_ff, rx_active_in;
   gfr_pkg::byte_type                   prev_byte_ff, prev_byte_in;
   logic [gfr_pkg::COUNT_BITS-1:0]      byte_count_ff, byte_count_in;
   gfr_pkg::byte_type                   payload_ff [gfr_pkg::PAYLOAD_LEN];
   gfr_pkg::byte_type                   payload_in [gfr_pkg::PAYLOAD_LEN];
   gfr_pkg::timer_type                  ms_frame_ff, ms_frame_in;
   gfr_pkg::timer_type                  ms_start_ff, ms_start_in;
   logic                                led_ff, led_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [gfr_pkg::WORD_BITS-1:0]       left_x_ff, left_y_ff, right_x_ff, right_y_ff;
   logic [gfr_pkg::WORD_BITS-1:0]       left_trig_ff, right_trig_ff;
   logic [gfr_pkg::BUTTON_BITS-1:0]     buttons_ff;
   logic                                done_ff, halt_ff, link_ff;

   logic                                fire;
   logic                                done_in, halt_in;
   gfr_pkg::timer_type                  ms_frame_inc, ms_start_inc;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;

   assign ms_frame_inc = (ms_frame_ff == '1) ? ms_frame_ff : ms_frame_ff + 1'b1;
   assign ms_start_inc = (ms_start_ff == '1) ? ms_start_ff : ms_start_ff + 1'b1;

   always_comb begin
      rx_active_in  = rx_active_ff;
      prev_byte_in  = prev_byte_ff;
      byte_count_in = byte_count_ff;
      payload_in    = payload_ff;
      ms_frame_in   = ms_frame_ff;
      ms_start_in   = ms_start_ff;
      led_in        = led_ff;
      done_in       = 1'b0;
      halt_in       = 1'b0;
      if (fire) begin
         if (req_chan.action == gfr_pkg::ACTION_TICK) begin
            ms_frame_in = ms_frame_inc;
            ms_start_in = ms_start_inc;
            if (rx_active_ff && (gfr_pkg::cmp_type'(ms_start_inc) >
                                 gfr_pkg::cmp_type'(cfg.receive_timeout_ms))) begin
               rx_active_in = 1'b0;
               prev_byte_in = '0;
            end
         end else if (rx_active_ff) begin
            if (byte_count_ff < gfr_pkg::COUNT_BITS'(gfr_pkg::PAYLOAD_LEN)) begin
               payload_in[byte_count_ff] = req_chan.data_byte;
               byte_count_in             = byte_count_ff + 1'b1;
            end else begin
               rx_active_in = 1'b0;
               led_in       = 1'b1;
               ms_frame_in  = '0;
               done_in      = 1'b1;
            end
         end else if ((req_chan.data_byte == gfr_pkg::SYNC_SECOND) &&
                      (prev_byte_ff == gfr_pkg::SYNC_FIRST)) begin
            byte_count_in = '0;
            rx_active_in  = 1'b1;
            prev_byte_in  = '0;
            ms_start_in   = '0;
         end else begin
            if (gfr_pkg::cmp_type'(ms_frame_ff) >
                gfr_pkg::cmp_type'(cfg.safety_timeout_ms)) begin
               halt_in = 1'b1;
               led_in  = 1'b0;
            end
            prev_byte_in = req_chan.data_byte;
         end
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_active_ff  <= 1'b0;
         prev_byte_ff  <= '0;
         byte_count_ff <= '0;
         for (int i = 0; i < gfr_pkg::PAYLOAD_LEN; i++) begin
            payload_ff[i] <= '0;
         end
         ms_frame_ff   <= '0;
         ms_start_ff   <= '0;
         led_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rx_active_ff  <= rx_active_in;
         prev_byte_ff  <= prev_byte_in;
         byte_count_ff <= byte_count_in;
         payload_ff    <= payload_in;
         ms_frame_ff   <= ms_frame_in;
         ms_start_ff   <= ms_start_in;
         led_ff        <= led_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         left_x_ff     <= {payload_in[3],  payload_in[2],  payload_in[1],  payload_in[0]};
         left_y_ff     <= {payload_in[7],  payload_in[6],  payload_in[5],  payload_in[4]};
         right_x_ff    <= {payload_in[11], payload_in[10], payload_in[9],  payload_in[8]};
         right_y_ff    <= {payload_in[15], payload_in[14], payload_in[13], payload_in[12]};
         left_trig_ff  <= {payload_in[19], payload_in[18], payload_in[17], payload_in[16]};
         right_trig_ff <= {payload_in[23], payload_in[22], payload_in[21], payload_in[20]};
         buttons_ff    <= {payload_in[gfr_pkg::AXIS_BYTES+1],
                           payload_in[gfr_pkg::AXIS_BYTES]};
         done_ff       <= done_in;
         halt_ff       <= halt_in;
         link_ff       <= led_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.left_x        = left_x_ff;
   assign rsp_chan.left_y        = left_y_ff;
   assign rsp_chan.right_x       = right_x_ff;
   assign rsp_chan.right_y       = right_y_ff;
   assign rsp_chan.left_trigger  = left_trig_ff;
   assign rsp_chan.right_trigger = right_trig_ff;
   assign rsp_chan.buttons       = buttons_ff;
   assign rsp_chan.frame_done    = done_ff;
   assign rsp_chan.halt_request  = halt_ff;
   assign rsp_chan.link_led      = link_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= gfr_pkg::COUNT_BITS'(gfr_pkg::PAYLOAD_LEN))
      else $error("byte count past payload length");

   a_done_lights_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> link_ff && !halt_ff)
      else $error("frame done without link led");

   a_halt_clears_led: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && halt_ff |-> !link_ff)
      else $error("halt with link led lit");

   a_done_ends_rx: assert property (@(posedge clock) disable iff (reset)
      fire && done_in |=> !rx_active_ff && (ms_frame_ff == '0))
      else $error("receive still active after frame done");

   a_sync_starts_rx: assert property (@(posedge clock) disable iff (reset)
      fire && !rx_active_ff && rx_active_in |=> (byte_count_ff == '0) && (ms_start_ff == '0))
      else $error("receive started without clearing count");

endmodule
`default_nettype wire
